>>> sv/h2cr_pkg.sv
// shared types, register and palette codes, and palette tables for the colour ramp
package h2cr_pkg;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   typedef enum logic [1:0] {
      REG_PALETTE = 2'd0,
      REG_LOW     = 2'd1,
      REG_HIGH    = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      PAL_GREY    = 2'd0,
      PAL_TERRAIN = 2'd1,
      PAL_HEAT    = 2'd2
   } palette_type;

   localparam int RegAddrBits = 4;

   localparam rgb_type GREY_PAL [2] = '{
      '{8'd0,   8'd0,   8'd0},
      '{8'd255, 8'd255, 8'd255}
   };

   localparam rgb_type TERRAIN_PAL [7] = '{
      '{8'd18,  8'd52,  8'd86},
      '{8'd52,  8'd118, 8'd168},
      '{8'd210, 8'd190, 8'd140},
      '{8'd91,  8'd145, 8'd76},
      '{8'd43,  8'd98,  8'd57},
      '{8'd125, 8'd116, 8'd105},
      '{8'd238, 8'd243, 8'd246}
   };

   localparam rgb_type HEAT_PAL [5] = '{
      '{8'd25,  8'd38,  8'd120},
      '{8'd32,  8'd177, 8'd208},
      '{8'd245, 8'd218, 8'd58},
      '{8'd239, 8'd119, 8'd35},
      '{8'd190, 8'd36,  8'd39}
   };

   // index of the last entry of a palette
   function automatic logic [2:0] pal_last(input logic [1:0] pal);
      logic [2:0] last;
      case (pal)
         PAL_GREY:    last = 3'd1;
         PAL_TERRAIN: last = 3'd6;
         PAL_HEAT:    last = 3'd4;
         default:     last = 3'd4;
      endcase
      return last;
   endfunction

   // unused palette code reads as black
   function automatic rgb_type pal_entry(input logic [1:0] pal, input logic [2:0] idx);
      rgb_type e;
      case (pal)
         PAL_GREY:    e = GREY_PAL[idx[0]];
         PAL_TERRAIN: e = (idx > 3'd6) ? TERRAIN_PAL[6] : TERRAIN_PAL[idx];
         PAL_HEAT:    e = (idx > 3'd4) ? HEAT_PAL[4] : HEAT_PAL[idx];
         default:     e = '0;
      endcase
      return e;
   endfunction

endpackage

>>> sv/h2cr_front.sv
// front stages: clamp the height into the bounds and scale by the index of the last palette entry
module h2cr_front
   import h2cr_pkg::*;
#(
   parameter int HEIGHT_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [1:0]             palette,
   input  logic [HEIGHT_BITS-1:0] low_height,
   input  logic [HEIGHT_BITS-1:0] high_height,
   input  logic                   range_ok,
   input  logic                   in_valid,
   output logic                   in_stall,
   input  logic [HEIGHT_BITS-1:0] in_height,
   output logic                   out_valid,
   input  logic                   out_stall,
   output logic [HEIGHT_BITS+2:0] out_scaled
);

   localparam int MW = HEIGHT_BITS + 3;

   logic                   v1_ff, v2_ff;
   logic                   en1, en2;
   logic [HEIGHT_BITS-1:0] clamp;
   logic [HEIGHT_BITS-1:0] d_in, d_ff;
   logic [MW-1:0]          m_in, m_ff;

   assign en2      = !v2_ff || !out_stall;
   assign en1      = !v1_ff || en2;
   assign in_stall = !en1;

   always_comb begin
      if (in_height < low_height) begin
         clamp = low_height;
      end else if (in_height > high_height) begin
         clamp = high_height;
      end else begin
         clamp = in_height;
      end
      d_in = range_ok ? (clamp - low_height) : '0;
   end

   assign m_in = MW'(d_ff) * MW'(pal_last(palette));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1 && in_valid) d_ff <= d_in;
      if (en2 && v1_ff)    m_ff <= m_in;
   end

   assign out_valid  = v2_ff;
   assign out_scaled = m_ff;

endmodule

>>> sv/h2cr_divider.sv
// pipelined restoring divider, one quotient bit per stage: pos = (scaled << frac) / span
module h2cr_divider
   import h2cr_pkg::*;
#(
   parameter int HEIGHT_BITS   = 16,
   parameter int FRACTION_BITS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [HEIGHT_BITS-1:0]   low_height,
   input  logic [HEIGHT_BITS-1:0]   high_height,
   input  logic                     in_valid,
   output logic                     in_stall,
   input  logic [HEIGHT_BITS+2:0]   in_scaled,
   output logic                     out_valid,
   input  logic                     out_stall,
   output logic [FRACTION_BITS+2:0] out_quotient
);

   localparam int HB = HEIGHT_BITS;
   localparam int QB = FRACTION_BITS + 3;

   logic [HB-1:0] span;
   logic [HB-1:0] r_src [QB];
   logic [QB-1:0] b_src [QB];
   logic [QB-1:0] q_src [QB];
   logic          v_src [QB];
   logic [HB-1:0] r_in  [QB];
   logic [QB-1:0] b_in  [QB];
   logic [QB-1:0] q_in  [QB];
   logic [HB-1:0] r_ff  [QB];
   logic [QB-1:0] b_ff  [QB];
   logic [QB-1:0] q_ff  [QB];
   logic          v_ff  [QB];
   logic          en    [QB];

   assign span = high_height - low_height;

   // remainder starts below span because scaled <= 6 * span
   assign r_src[0] = in_scaled[HB+2:3];
   assign b_src[0] = {in_scaled[2:0], {FRACTION_BITS{1'b0}}};
   assign q_src[0] = '0;
   assign v_src[0] = in_valid;

   assign en[QB-1] = !v_ff[QB-1] || !out_stall;

   for (genvar k = 0; k < QB; k++) begin : g_stage
      logic [HB:0] trial;
      logic        ge;

      if (k > 0) begin : g_link
         assign r_src[k] = r_ff[k-1];
         assign b_src[k] = b_ff[k-1];
         assign q_src[k] = q_ff[k-1];
         assign v_src[k] = v_ff[k-1];
      end
      if (k < QB - 1) begin : g_en
         assign en[k] = !v_ff[k] || en[k+1];
      end

      always_comb begin
         trial   = {r_src[k], b_src[k][QB-1]};
         ge      = trial >= {1'b0, span};
         r_in[k] = ge ? HB'(trial - {1'b0, span}) : trial[HB-1:0];
         b_in[k] = b_src[k] << 1;
         q_in[k] = {q_src[k][QB-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en[k]) begin
            v_ff[k] <= v_src[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en[k] && v_src[k]) begin
            r_ff[k] <= r_in[k];
            b_ff[k] <= b_in[k];
            q_ff[k] <= q_in[k];
         end
      end
   end

   assign in_stall     = !en[0];
   assign out_valid    = v_ff[QB-1];
   assign out_quotient = q_ff[QB-1];

endmodule

>>> sv/h2cr_blend.sv
// back stages: pick the two neighboring entries and blend them by the fraction
module h2cr_blend
   import h2cr_pkg::*;
#(
   parameter int FRACTION_BITS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [1:0]               palette,
   input  logic                     range_ok,
   input  logic                     in_valid,
   output logic                     in_stall,
   input  logic [FRACTION_BITS+2:0] in_quotient,
   output logic                     out_valid,
   input  logic                     out_stall,
   output logic [7:0]               out_red,
   output logic [7:0]               out_green,
   output logic [7:0]               out_blue
);

   localparam int F  = FRACTION_BITS;
   localparam int TW = F + 9;
   localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

   logic               v1_ff, v2_ff;
   logic               en1, en2;
   logic [2:0]         last, idx, up;
   logic [F-1:0]       frac;
   rgb_type            a_in, b_in, a_ff, b_ff;
   logic [F-1:0]       frac_ff;
   logic [F:0]         wt;
   rgb_type            mix_in, mix_ff;

   function automatic logic [7:0] mix(input logic [7:0] a, input logic [7:0] b,
                                      input logic [F:0] wa, input logic [F-1:0] wb);
      logic [TW-1:0] t;
      t = TW'(a) * TW'(wa) + TW'(b) * TW'(wb);
      return t[F+7:F];
   endfunction

   assign en2      = !v2_ff || !out_stall;
   assign en1      = !v1_ff || en2;
   assign in_stall = !en1;

   always_comb begin
      last = pal_last(palette);
      idx  = in_quotient[F+2:F];
      frac = in_quotient[F-1:0];
      if (!range_ok) begin
         idx  = 3'd0;
         frac = '0;
      end else if (idx >= last) begin
         // top of the range lands exactly on the last entry
         idx  = last;
         frac = '0;
      end
      up   = (idx >= last) ? last : idx + 3'd1;
      a_in = pal_entry(palette, idx);
      b_in = pal_entry(palette, up);
   end

   always_comb begin
      wt           = ONE - {1'b0, frac_ff};
      mix_in.red   = mix(a_ff.red,   b_ff.red,   wt, frac_ff);
      mix_in.green = mix(a_ff.green, b_ff.green, wt, frac_ff);
      mix_in.blue  = mix(a_ff.blue,  b_ff.blue,  wt, frac_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1 && in_valid) begin
         a_ff    <= a_in;
         b_ff    <= b_in;
         frac_ff <= frac;
      end
      if (en2 && v1_ff) mix_ff <= mix_in;
   end

   assign out_valid = v2_ff;
   assign out_red   = mix_ff.red;
   assign out_green = mix_ff.green;
   assign out_blue  = mix_ff.blue;

endmodule

>>> sv/height_to_colour_ramp_unit.sv
// Height to RGB colour ramp: takes one height beat per cycle while not stalled and
// returns one colour beat per height: the front stages clamp and then scale the height,
// the divider spends one stage per quotient bit (FRACTION_BITS + 3), and the back
// stages pick and blend the palette entries. Every stage holds its beat under stall
// and fills bubbles, so a new height is taken whenever the pipeline has room.
// Registers: palette select at 0x0, low height at 0x4, high height at 0x8; write them
// only while no beat is in flight.
module height_to_colour_ramp_unit
   import h2cr_pkg::*;
#(
   parameter int HEIGHT_BITS   = 16,
   parameter int FRACTION_BITS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [HEIGHT_BITS-1:0] req_height_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_red,
   output logic [7:0]             rsp_green,
   output logic [7:0]             rsp_blue,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [RegAddrBits-1:0] paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   localparam int QB = FRACTION_BITS + 3;

   logic [1:0]             palette_ff;
   logic [HEIGHT_BITS-1:0] low_ff, high_ff;
   logic                   wr_en;
   logic                   range_ok;
   logic                   f_valid, f_stall;
   logic [HEIGHT_BITS+2:0] f_scaled;
   logic                   d_valid, d_stall;
   logic [QB-1:0]          d_quotient;

   assign pready   = 1'b1;
   assign wr_en    = psel && penable && pwrite;
   assign range_ok = high_ff > low_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         palette_ff <= PAL_GREY;
         low_ff     <= '0;
         high_ff    <= '1;
      end else if (wr_en) begin
         case (paddr[3:2])
            REG_PALETTE: palette_ff <= pwdata[1:0];
            REG_LOW:     low_ff     <= pwdata[HEIGHT_BITS-1:0];
            REG_HIGH:    high_ff    <= pwdata[HEIGHT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_PALETTE: prdata = 32'(palette_ff);
         REG_LOW:     prdata = 32'(low_ff);
         REG_HIGH:    prdata = 32'(high_ff);
         default:     prdata = '0;
      endcase
   end

   h2cr_front #(
      .HEIGHT_BITS(HEIGHT_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .palette    (palette_ff),
      .low_height (low_ff),
      .high_height(high_ff),
      .range_ok   (range_ok),
      .in_valid   (req_valid),
      .in_stall   (req_stall),
      .in_height  (req_height_sample),
      .out_valid  (f_valid),
      .out_stall  (f_stall),
      .out_scaled (f_scaled)
   );

   h2cr_divider #(
      .HEIGHT_BITS  (HEIGHT_BITS),
      .FRACTION_BITS(FRACTION_BITS)
   ) u_divider (
      .clock       (clock),
      .reset       (reset),
      .low_height  (low_ff),
      .high_height (high_ff),
      .in_valid    (f_valid),
      .in_stall    (f_stall),
      .in_scaled   (f_scaled),
      .out_valid   (d_valid),
      .out_stall   (d_stall),
      .out_quotient(d_quotient)
   );

   h2cr_blend #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_blend (
      .clock      (clock),
      .reset      (reset),
      .palette    (palette_ff),
      .range_ok   (range_ok),
      .in_valid   (d_valid),
      .in_stall   (d_stall),
      .in_quotient(d_quotient),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_red    (rsp_red),
      .out_green  (rsp_green),
      .out_blue   (rsp_blue)
   );

endmodule

>>> sv/h2cr_checker.sv
// port-level assertions for the colour ramp, bound to the top level
module h2cr_checker
   import h2cr_pkg::*;
#(
   parameter int HEIGHT_BITS = 16
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [7:0]             rsp_red,
   input logic [7:0]             rsp_green,
   input logic [7:0]             rsp_blue,
   input logic                   psel,
   input logic                   penable,
   input logic                   pwrite,
   input logic [RegAddrBits-1:0] paddr,
   input logic [31:0]            pwdata,
   input logic [31:0]            prdata
);

   // a stalled result beat stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_red) && $stable(rsp_green)
         && $stable(rsp_blue))
      else $error("result beat changed under stall");

   // the pipeline always has room unless the output is blocked
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && (!rsp_valid || !rsp_stall) |-> !req_stall)
      else $error("input stalled while the output drains");

   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat survived reset");

   a_low_readback: assert property (@(posedge clock) disable iff (reset)
      psel && !pwrite && paddr[3:2] == REG_LOW && !$past(reset)
         && $past(psel && penable && pwrite && paddr[3:2] == REG_LOW)
         |-> prdata == 32'($past(pwdata[HEIGHT_BITS-1:0])))
      else $error("low height readback mismatch");

endmodule

bind height_to_colour_ramp_unit h2cr_checker #(
   .HEIGHT_BITS(HEIGHT_BITS)
) u_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_red  (rsp_red),
   .rsp_green(rsp_green),
   .rsp_blue (rsp_blue),
   .psel     (psel),
   .penable  (penable),
   .pwrite   (pwrite),
   .paddr    (paddr),
   .pwdata   (pwdata),
   .prdata   (prdata)
);
